/* design/bls_pkg.sv */
// Shared types and constants for the bracketing line search block.
// No dependencies; every other design file imports this package.
`default_nettype none

package bls_pkg;

    localparam int STEP_W = 16;
    localparam int COST_W = 32;
    localparam int FRAC_W = 14;
    localparam int CFG_INDEX_W = 2;

    typedef logic [STEP_W-1:0] step_t;
    typedef logic signed [COST_W-1:0] cost_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    typedef enum logic [1:0] {
        ST_EVAL    = 2'd0,
        ST_FINAL   = 2'd1,
        ST_IGNORED = 2'd2
    } status_t;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_REPLY = 1'b1;

    localparam cfg_index_t REG_MIN_STEP    = 2'd0;
    localparam cfg_index_t REG_MAX_STEP    = 2'd1;
    localparam cfg_index_t REG_CUTOFF_STEP = 2'd2;
    localparam cfg_index_t REG_HASTY_MODE  = 2'd3;

    localparam step_t MIN_STEP_RESET    = 16'd1638;
    localparam step_t MAX_STEP_RESET    = 16'd16384;
    localparam step_t CUTOFF_STEP_RESET = 16'd1638;

    typedef struct packed {
        status_t status;
        step_t   step_size;
    } result_t;

    function automatic step_t half_sum(input step_t a, input step_t b);
        logic [STEP_W:0] sum;
        begin
            sum = {1'b0, a} + {1'b0, b};
            return sum[STEP_W:1];
        end
    endfunction

endpackage

`default_nettype wire

/* design/bls_ifs.sv */
// Valid/ready channel interfaces for the bracketing line search block.
// Depends on bls_pkg for field widths.
`default_nettype none

interface bls_item_if;
    import bls_pkg::*;
    logic  valid;
    logic  ready;
    logic  cmd;
    cost_t cost;
    modport source (output valid, output cmd, output cost, input ready);
    modport sink (input valid, input cmd, input cost, output ready);
endinterface

interface bls_result_if;
    import bls_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    step_t       step_size;
    modport source (output valid, output status, output step_size, input ready);
    modport sink (input valid, input status, input step_size, output ready);
endinterface

interface bls_cfg_if;
    import bls_pkg::*;
    logic       valid;
    logic       ready;
    cfg_index_t index;
    step_t      data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* design/bls_core.sv */
// Search state, configuration registers and the per-item decision logic.
// Depends on bls_pkg and the bls_cfg_if interface.
`default_nettype none

module bls_core
    import bls_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    bls_cfg_if.sink    cfg,
    input  wire logic  item_accept,
    input  wire logic  item_cmd,
    input  wire cost_t item_cost,
    output result_t    result
);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_MIN    = 3'd1,
        PH_MAX    = 3'd2,
        PH_SHRINK = 3'd3,
        PH_BISECT = 3'd4
    } phase_t;

    step_t  min_step_reg, max_step_reg, cutoff_step_reg;
    logic   hasty_mode_reg;

    phase_t phase_reg, phase_next;
    step_t  low_reg, low_next, mid_reg, mid_next, high_reg, high_next;
    cost_t  cost_low_reg, cost_low_next, cost_mid_reg, cost_mid_next;
    cost_t  cost_high_reg, cost_high_next;
    step_t  probe_reg, probe_next;
    logic   left_reg, left_next;
    step_t  rel_cut_reg, rel_cut_next;

    logic signed [STEP_W:0] diff;
    logic [2*STEP_W-1:0]    prod;
    step_t                  width, left_span, right_span;
    logic                   bisect_done, bisect_left, shrink_go;
    step_t                  bisect_probe;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        diff = $signed({1'b0, max_step_reg}) - $signed({1'b0, min_step_reg});
        prod = cutoff_step_reg * diff[STEP_W-1:0];

        phase_next     = phase_reg;
        low_next       = low_reg;
        mid_next       = mid_reg;
        high_next      = high_reg;
        cost_low_next  = cost_low_reg;
        cost_mid_next  = cost_mid_reg;
        cost_high_next = cost_high_reg;
        probe_next     = probe_reg;
        left_next      = left_reg;
        rel_cut_next   = rel_cut_reg;

        unique case (phase_reg)
            PH_MAX:
            begin
                cost_mid_next  = item_cost;
                cost_high_next = item_cost;
            end
            PH_SHRINK:
            begin
                mid_next      = probe_reg;
                cost_mid_next = item_cost;
            end
            PH_BISECT:
            begin
                if (left_reg)
                begin
                    if (item_cost <= cost_mid_reg)
                    begin
                        high_next      = mid_reg;
                        cost_high_next = cost_mid_reg;
                        mid_next       = probe_reg;
                        cost_mid_next  = item_cost;
                    end
                    else
                    begin
                        low_next      = probe_reg;
                        cost_low_next = item_cost;
                    end
                end
                else
                begin
                    if (item_cost < cost_mid_reg)
                    begin
                        low_next      = mid_reg;
                        cost_low_next = cost_mid_reg;
                        mid_next      = probe_reg;
                        cost_mid_next = item_cost;
                    end
                    else
                    begin
                        high_next      = probe_reg;
                        cost_high_next = item_cost;
                    end
                end
            end
            default:
            begin
            end
        endcase

        width        = high_next - low_next;
        left_span    = mid_next - low_next;
        right_span   = high_next - mid_next;
        bisect_done  = (width <= cutoff_step_reg) || (width <= step_t'(1));
        bisect_left  = left_span > right_span;
        bisect_probe = bisect_left ? half_sum(low_next, mid_next)
                                   : half_sum(mid_next, high_next);
        shrink_go    = (cost_mid_next > cost_low_next) && (left_span > rel_cut_reg);

        result.status    = ST_IGNORED;
        result.step_size = '0;

        if (item_cmd == CMD_START)
        begin
            if (diff < $signed({1'b0, cutoff_step_reg}))
            begin
                phase_next       = PH_IDLE;
                result.status    = ST_FINAL;
                result.step_size = half_sum(min_step_reg, max_step_reg);
            end
            else
            begin
                rel_cut_next     = (|prod[2*STEP_W-1:STEP_W+FRAC_W]) ? '1
                                   : prod[STEP_W+FRAC_W-1:FRAC_W];
                low_next         = min_step_reg;
                mid_next         = max_step_reg;
                high_next        = max_step_reg;
                phase_next       = PH_MIN;
                probe_next       = min_step_reg;
                result.status    = ST_EVAL;
                result.step_size = min_step_reg;
            end
        end
        else if (phase_reg == PH_MIN)
        begin
            cost_low_next    = item_cost;
            phase_next       = PH_MAX;
            probe_next       = high_reg;
            result.status    = ST_EVAL;
            result.step_size = high_reg;
        end
        else if (phase_reg == PH_IDLE)
        begin
            result.status    = ST_IGNORED;
            result.step_size = '0;
        end
        else if (phase_reg == PH_MAX && hasty_mode_reg && item_cost <= cost_low_reg)
        begin
            phase_next       = PH_IDLE;
            result.status    = ST_FINAL;
            result.step_size = high_reg;
        end
        else if ((phase_reg == PH_SHRINK || (phase_reg == PH_MAX && item_cost > cost_low_reg))
                 && shrink_go)
        begin
            phase_next       = PH_SHRINK;
            probe_next       = half_sum(low_next, mid_next);
            result.status    = ST_EVAL;
            result.step_size = half_sum(low_next, mid_next);
        end
        else if ((phase_reg == PH_SHRINK || (phase_reg == PH_MAX && item_cost > cost_low_reg))
                 && hasty_mode_reg)
        begin
            phase_next       = PH_IDLE;
            result.status    = ST_FINAL;
            result.step_size = mid_next;
        end
        else if (bisect_done)
        begin
            phase_next       = PH_IDLE;
            result.status    = ST_FINAL;
            result.step_size = low_next;
        end
        else
        begin
            phase_next       = PH_BISECT;
            left_next        = bisect_left;
            probe_next       = bisect_probe;
            result.status    = ST_EVAL;
            result.step_size = bisect_probe;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_step_reg    <= MIN_STEP_RESET;
            max_step_reg    <= MAX_STEP_RESET;
            cutoff_step_reg <= CUTOFF_STEP_RESET;
            hasty_mode_reg  <= 1'b0;
            phase_reg       <= PH_IDLE;
            low_reg         <= '0;
            mid_reg         <= '0;
            high_reg        <= '0;
            cost_low_reg    <= '0;
            cost_mid_reg    <= '0;
            cost_high_reg   <= '0;
            probe_reg       <= '0;
            left_reg        <= 1'b0;
            rel_cut_reg     <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_MIN_STEP:    min_step_reg    <= cfg.data;
                    REG_MAX_STEP:    max_step_reg    <= cfg.data;
                    REG_CUTOFF_STEP: cutoff_step_reg <= cfg.data;
                    REG_HASTY_MODE:  hasty_mode_reg  <= cfg.data[0];
                endcase
            end
            if (item_accept)
            begin
                phase_reg     <= phase_next;
                low_reg       <= low_next;
                mid_reg       <= mid_next;
                high_reg      <= high_next;
                cost_low_reg  <= cost_low_next;
                cost_mid_reg  <= cost_mid_next;
                cost_high_reg <= cost_high_next;
                probe_reg     <= probe_next;
                left_reg      <= left_next;
                rel_cut_reg   <= rel_cut_next;
            end
        end
    end

endmodule

`default_nettype wire

/* design/bls_out_buf.sv */
// Two-entry output buffer: result register plus skid register.
// Depends on bls_pkg and the bls_result_if interface.
`default_nettype none

module bls_out_buf
    import bls_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         can_push,
    bls_result_if.source result
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign can_push         = !skid_valid_reg;
    assign pop              = main_valid_reg && result.ready;
    assign result.valid     = main_valid_reg;
    assign result.status    = main_reg.status;
    assign result.step_size = main_reg.step_size;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop && skid_valid_reg)
        begin
            main_next       = skid_reg;
            skid_valid_next = 1'b0;
        end
        else if (push && (!main_valid_reg || pop))
        begin
            main_next       = push_data;
            main_valid_next = 1'b1;
        end
        else if (push)
        begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

/* design/bracketing_line_search_top.sv */
// Top level of the bracketing line search controller.
// Depends on bls_pkg, the channel interfaces, bls_core and bls_out_buf.
//
// The item channel takes commands: a start transfer (cmd 0) begins a search
// over the configured step range, and a reply transfer (cmd 1) returns the
// cost at the step that was last asked for. Every item yields exactly one
// transfer on the result channel: status 0 asks for the cost at step_size,
// status 1 gives the final step size, and status 2 marks a reply that arrived
// with no search running. The cfg channel writes min_step, max_step,
// cutoff_step and hasty_mode by index and is always ready.
//
// An item is decided in the cycle it is accepted, and its result is registered
// in the output buffer. The block takes one item per cycle while ready is high.
// Results wait in a two-entry buffer, so the item channel stays ready while
// one result is pending and drops ready whenever two are pending. Reset
// returns the registers to their defaults, ends any search and empties the
// buffer; the block accepts items right after reset.
`default_nettype none

module bracketing_line_search_top
    import bls_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    bls_item_if.sink     item,
    bls_result_if.source result,
    bls_cfg_if.sink      cfg
);

    result_t core_result;
    logic    can_push;
    logic    item_accept;

    assign item.ready  = can_push;
    assign item_accept = item.valid && can_push;

    bls_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .item_accept (item_accept),
        .item_cmd    (item.cmd),
        .item_cost   (item.cost),
        .result      (core_result)
    );

    bls_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (item_accept),
        .push_data (core_result),
        .can_push  (can_push),
        .result    (result)
    );

endmodule

`default_nettype wire

/* design/bls_checker.sv */
// Port-level checks for the bracketing line search top level, with its bind.
// Depends on bls_pkg for the status codes.
`default_nettype none

module bls_checker
    import bls_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        item_valid,
    input wire logic        item_ready,
    input wire logic        result_valid,
    input wire logic        result_ready,
    input wire logic [1:0]  result_status,
    input wire logic [15:0] result_step_size
);

    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> result_valid)
        else $error("Accepted item produced no pending result.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
        else $error("Item channel stalled with an empty output buffer.");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_status == ST_IGNORED |-> result_step_size == 16'd0)
        else $error("Ignored item reported a nonzero step size.");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_step_size))
        else $error("Stalled result was dropped or changed.");

endmodule

bind bracketing_line_search_top bls_checker u_bls_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_valid       (item.valid),
    .item_ready       (item.ready),
    .result_valid     (result.valid),
    .result_ready     (result.ready),
    .result_status    (result.status),
    .result_step_size (result.step_size)
);

`default_nettype wire

/* sim/tb_bracketing_line_search_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for bracketing_line_search_top, built on bls_pkg and
// the channel interfaces. A behavioral copy of the search predicts each result
// transfer, and a checker compares every one of them in order.

module tb_bracketing_line_search_top;
    import bls_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_AT_MIN,
        PH_AT_MAX,
        PH_SHRINK,
        PH_BISECT
    } search_phase_t;

    typedef enum int {
        SHAPE_BOWL,
        SHAPE_VEE,
        SHAPE_RIDGE,
        SHAPE_FLAT,
        SHAPE_NOISE
    } cost_shape_t;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS = 550;
    localparam int REPORT_LIMIT = 10;

    logic clk;
    logic rst_n;

    bls_item_if   item_ch ();
    bls_result_if res_ch ();
    bls_cfg_if    cfg_ch ();

    bracketing_line_search_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    step_t reg_min;
    step_t reg_max;
    step_t reg_cutoff;
    logic  reg_hasty;

    search_phase_t phase_now;
    step_t         br_low;
    step_t         br_mid;
    step_t         br_high;
    step_t         probe_at;
    step_t         rel_cutoff;
    cost_t         cost_low;
    cost_t         cost_mid;
    cost_t         cost_high;
    logic          probe_left;

    result_t pending_results[$];
    int      mismatch_count = 0;
    int      item_count = 0;
    int      hold_left = 0;
    bit      calm = 1'b0;

    cost_shape_t shape;
    step_t       target;
    int          bias;
    int          slope;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void search_reset();
        reg_min = MIN_STEP_RESET;
        reg_max = MAX_STEP_RESET;
        reg_cutoff = CUTOFF_STEP_RESET;
        reg_hasty = 1'b0;
        phase_now = PH_IDLE;
        br_low = '0;
        br_mid = '0;
        br_high = '0;
        probe_at = '0;
        rel_cutoff = '0;
        cost_low = '0;
        cost_mid = '0;
        cost_high = '0;
        probe_left = 1'b0;
    endfunction

    function automatic step_t midpoint(input step_t a, input step_t b);
        return step_t'((32'(a) + 32'(b)) >> 1);
    endfunction

    function automatic result_t make_result(input status_t st, input step_t s);
        result_t r;
        r.status = st;
        r.step_size = s;
        return r;
    endfunction

    function automatic result_t ask_cost(input search_phase_t ph, input step_t s);
        phase_now = ph;
        probe_at = s;
        return make_result(ST_EVAL, s);
    endfunction

    function automatic result_t answer(input step_t s);
        phase_now = PH_IDLE;
        return make_result(ST_FINAL, s);
    endfunction

    function automatic result_t bisect_next();
        logic [31:0] span;
        span = 32'(br_high) - 32'(br_low);
        if (span <= 32'(reg_cutoff) || span <= 32'd1)
            return answer(br_low);
        probe_left = (32'(br_mid) - 32'(br_low)) > (32'(br_high) - 32'(br_mid));
        if (probe_left)
            return ask_cost(PH_BISECT, midpoint(br_low, br_mid));
        return ask_cost(PH_BISECT, midpoint(br_mid, br_high));
    endfunction

    function automatic result_t shrink_next();
        if (cost_mid > cost_low && (32'(br_mid) - 32'(br_low)) > 32'(rel_cutoff))
            return ask_cost(PH_SHRINK, midpoint(br_low, br_mid));
        if (reg_hasty)
            return answer(br_mid);
        return bisect_next();
    endfunction

    function automatic result_t search_predict(input logic cmd, input cost_t c);
        int          span;
        logic [63:0] scaled;
        if (cmd == CMD_START)
        begin
            span = int'(reg_max) - int'(reg_min);
            if (span < int'(reg_cutoff))
                return answer(midpoint(reg_min, reg_max));
            scaled = (64'(reg_cutoff) * 64'(span)) >> FRAC_W;
            rel_cutoff = (scaled > 64'hFFFF) ? 16'hFFFF : scaled[15:0];
            br_low = reg_min;
            br_mid = reg_max;
            br_high = reg_max;
            return ask_cost(PH_AT_MIN, reg_min);
        end
        case (phase_now)
            PH_AT_MIN:
            begin
                cost_low = c;
                return ask_cost(PH_AT_MAX, br_high);
            end
            PH_AT_MAX:
            begin
                cost_mid = c;
                cost_high = c;
                if (reg_hasty && cost_high <= cost_low)
                    return answer(br_high);
                if (cost_high > cost_low)
                    return shrink_next();
                return bisect_next();
            end
            PH_SHRINK:
            begin
                br_mid = probe_at;
                cost_mid = c;
                return shrink_next();
            end
            PH_BISECT:
            begin
                if (probe_left)
                begin
                    if (c <= cost_mid)
                    begin
                        br_high = br_mid;
                        cost_high = cost_mid;
                        br_mid = probe_at;
                        cost_mid = c;
                    end
                    else
                    begin
                        br_low = probe_at;
                        cost_low = c;
                    end
                end
                else
                begin
                    if (c < cost_mid)
                    begin
                        br_low = br_mid;
                        cost_low = cost_mid;
                        br_mid = probe_at;
                        cost_mid = c;
                    end
                    else
                    begin
                        br_high = probe_at;
                        cost_high = c;
                    end
                end
                return bisect_next();
            end
            default:
                return make_result(ST_IGNORED, '0);
        endcase
    endfunction

    function automatic cost_t cost_at(input step_t s);
        longint d;
        longint mag;
        d = longint'(s) - longint'(target);
        mag = (d < 0) ? -d : d;
        case (shape)
            SHAPE_BOWL:  return cost_t'(((d * d) >>> 2) + longint'(bias));
            SHAPE_VEE:   return cost_t'(mag * slope + longint'(bias));
            SHAPE_RIDGE: return cost_t'(longint'(bias) - mag * slope);
            SHAPE_FLAT:  return cost_t'(bias);
            default:     return cost_t'($urandom);
        endcase
    endfunction

    function automatic int pick_gap();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(input logic cmd, input cost_t c, output result_t predicted);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.cmd <= cmd;
        item_ch.cost <= c;
        do
            @(posedge clk);
        while (!item_ch.ready);
        predicted = search_predict(cmd, c);
        pending_results.push_back(predicted);
        if (predicted.status != ST_IGNORED)
            item_count++;
    endtask

    task automatic settle();
        item_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input step_t value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_MIN_STEP:    reg_min = value;
            REG_MAX_STEP:    reg_max = value;
            REG_CUTOFF_STEP: reg_cutoff = value;
            REG_HASTY_MODE:  reg_hasty = value[0];
        endcase
        @(posedge clk);
    endtask

    task automatic apply_config(input step_t lo, input step_t hi, input step_t cut,
                                input logic hasty);
        settle();
        write_reg(REG_MIN_STEP, lo);
        write_reg(REG_MAX_STEP, hi);
        write_reg(REG_CUTOFF_STEP, cut);
        write_reg(REG_HASTY_MODE, step_t'(hasty));
    endtask

    task automatic run_search(input int noise_pct);
        result_t r;
        int      roll;
        shape = cost_shape_t'($urandom_range(0, 4));
        if ($urandom_range(0, 1) == 0)
            target = reg_min + step_t'($urandom_range(0, 2000));
        else
            target = step_t'($urandom_range(0, 65535));
        bias = int'($urandom_range(0, 2000000)) - 1000000;
        slope = $urandom_range(1, 32767);
        send_item(CMD_START, cost_t'($urandom), r);
        while (r.status == ST_EVAL)
        begin
            roll = $urandom_range(0, 99);
            if (roll < noise_pct / 2)
                send_item(CMD_START, cost_t'($urandom), r);
            else if (roll < noise_pct)
                send_item(CMD_REPLY, cost_t'($urandom), r);
            else
                send_item(CMD_REPLY, cost_at(r.step_size), r);
        end
    endtask

    task automatic random_config();
        step_t lo;
        step_t hi;
        step_t cut;
        case ($urandom_range(0, 5))
            0:
            begin
                lo = 16'd0;
                hi = 16'hFFFF;
            end
            1:
            begin
                lo = step_t'($urandom_range(0, 1000));
                hi = step_t'($urandom_range(60000, 65535));
            end
            2:
            begin
                lo = step_t'($urandom_range(0, 65535));
                hi = step_t'($urandom_range(0, 65535));
            end
            3:
            begin
                lo = step_t'($urandom_range(0, 65535));
                hi = lo;
            end
            default:
            begin
                lo = step_t'($urandom_range(0, 65535));
                hi = lo + step_t'($urandom_range(0, 65535 - int'(lo)));
            end
        endcase
        case ($urandom_range(0, 6))
            0:       cut = 16'd0;
            1:       cut = 16'hFFFF;
            2:       cut = step_t'($urandom_range(0, 16));
            3:       cut = step_t'($urandom_range(0, 65535));
            default: cut = step_t'($urandom_range(64, 4096));
        endcase
        apply_config(lo, hi, cut, $urandom_range(0, 3) == 0);
    endtask

    task automatic test_idle_replies();
        result_t r;
        send_item(CMD_REPLY, 32'sh7FFFFFFF, r);
        send_item(CMD_REPLY, 32'sh80000000, r);
    endtask

    task automatic test_default_search();
        result_t r;
        shape = SHAPE_BOWL;
        target = 16'd3000;
        bias = 0;
        send_item(CMD_START, '0, r);
        while (r.status == ST_EVAL)
            send_item(CMD_REPLY, cost_at(r.step_size), r);
    endtask

    task automatic test_narrow_ranges();
        result_t r;
        apply_config(16'd5000, 16'd5000, 16'd1, 1'b0);
        send_item(CMD_START, '0, r);
        apply_config(16'd60000, 16'd100, 16'd0, 1'b0);
        send_item(CMD_START, '0, r);
        apply_config(16'hFFFF, 16'hFFFF, 16'd1, 1'b0);
        send_item(CMD_START, '0, r);
    endtask

    task automatic test_hasty_and_saturation();
        result_t r;
        apply_config(16'd0, 16'hFFFF, 16'hFFFF, 1'b1);
        send_item(CMD_START, '0, r);
        send_item(CMD_REPLY, '0, r);
        send_item(CMD_REPLY, -32'sd5, r);
        send_item(CMD_START, '0, r);
        send_item(CMD_REPLY, 32'sh80000000, r);
        send_item(CMD_REPLY, 32'sh7FFFFFFF, r);
    endtask

    task automatic test_restart_and_live_writes();
        result_t r;
        apply_config(16'd0, 16'hFFFF, 16'd0, 1'b0);
        send_item(CMD_START, '0, r);
        send_item(CMD_REPLY, -32'sd1, r);
        send_item(CMD_START, '0, r);
        send_item(CMD_REPLY, -32'sd1, r);
        settle();
        write_reg(REG_MAX_STEP, 16'd100);
        write_reg(REG_CUTOFF_STEP, 16'hFFFF);
        send_item(CMD_REPLY, 32'sd5, r);
        send_item(CMD_REPLY, 32'sh80000000, r);
        send_item(CMD_START, '0, r);
    endtask

    task automatic test_backpressure();
        apply_config(16'd0, 16'hFFFF, 16'd0, 1'b0);
        calm = 1'b1;
        hold_left = HOLD_CYCLES;
        run_search(0);
        calm = 1'b0;
    endtask

    task automatic test_random_searches();
        result_t r;
        int      goal;
        goal = item_count + RANDOM_ITEMS;
        while (item_count < goal)
        begin
            random_config();
            calm = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(2, 6))
            begin
                run_search(6);
                if ($urandom_range(0, 4) == 0)
                    send_item(CMD_REPLY, cost_t'($urandom), r);
            end
        end
        calm = 1'b0;
    endtask

    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: unexpected result transfer: status %0d step_size %0d",
                             $time, res_ch.status, res_ch.step_size);
            end
            else
            begin
                want = pending_results.pop_front();
                if (res_ch.status !== 2'(want.status) || res_ch.step_size !== want.step_size)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: mismatch: status exp %0d got %0d, step_size exp %0d got %0d",
                                 $time, want.status, res_ch.status, want.step_size,
                                 res_ch.step_size);
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        int quiet_cycles;
        if (rst_n !== 1'b1 || (item_ch.valid && item_ch.ready) ||
            (res_ch.valid && res_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("FAIL bracketing_line_search_top");
            $finish;
        end
    end

    initial
    begin : stimulus
        rst_n <= 1'b0;
        item_ch.valid <= 1'b0;
        item_ch.cmd <= CMD_START;
        item_ch.cost <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_MIN_STEP;
        cfg_ch.data <= '0;
        search_reset();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_replies();
        test_default_search();
        test_narrow_ranges();
        test_hasty_and_saturation();
        test_restart_and_live_writes();
        test_backpressure();
        test_random_searches();

        settle();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("PASS bracketing_line_search_top");
        else
            $display("FAIL bracketing_line_search_top");
        $finish;
    end

endmodule
